// ===== rtl/mp2w_pkg.sv =====
// ----------------------------------------------------------------------------
// mp2w_pkg
// shared types and constants of the 2-d max pooling window core
// ----------------------------------------------------------------------------
`default_nettype none

package mp2w_pkg;

    // most results one pixel may cause, further ones of the run are dropped
    localparam int RESULT_CAP = 64;
    localparam int CNT_W      = 7;

    localparam int OUT_X_W    = 11;
    localparam int OUT_Y_W    = 17;
    localparam int Y_W        = 16;
    localparam int EY_W       = 18;
    localparam int W_REG_W    = 11;
    localparam int K_W        = 4;
    localparam int S_W        = 4;
    localparam int P_W        = 3;
    localparam int NCOL_W     = 4;
    localparam int RREM_W     = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IN_WIDTH    = 3'd0,
        REG_IN_HEIGHT   = 3'd1,
        REG_KERNEL_SIZE = 3'd2,
        REG_STRIDE      = 3'd3,
        REG_PAD         = 3'd4
    } cfg_reg_t;

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_COLSCAN = 9'b000000010,
        ST_ROW     = 9'b000000100,
        ST_WINIT   = 9'b000001000,
        ST_WIN     = 9'b000010000,
        ST_DRAIN   = 9'b000100000,
        ST_OUT     = 9'b001000000,
        ST_ROWADV  = 9'b010000000,
        ST_ADVANCE = 9'b100000000
    } state_t;

    typedef struct packed {
        logic accept;
        logic col_step;
        logic win_init;
        logic win_step;
        logic load_out;
        logic out_done;
        logic row_adv;
        logic advance;
    } cmd_t;

    typedef struct packed {
        logic col_hit;
        logic row_hit;
        logic row_hit_base;
        logic n_ok;
        logic ncol_nz;
        logic col_more;
        logic last;
        logic x_last;
        logic win_done;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/mp2w_ctrl.sv =====
// ----------------------------------------------------------------------------
// mp2w_ctrl
// sequencer: column scan, per-result window walk, output transfer, advance
// ----------------------------------------------------------------------------
`default_nettype none

module mp2w_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    input  wire logic              m_tready,
    input  mp2w_pkg::status_t      status,
    output mp2w_pkg::cmd_t         cmd,
    output logic                   s_ready,
    output logic                   m_valid
);

    mp2w_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mp2w_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            mp2w_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = mp2w_pkg::ST_COLSCAN;
                end
            end
            mp2w_pkg::ST_COLSCAN: begin
                if (status.col_hit) begin
                    cmd.col_step = 1'b1;
                end else begin
                    state_next = mp2w_pkg::ST_ROW;
                end
            end
            mp2w_pkg::ST_ROW: begin
                if (status.row_hit && status.n_ok && status.ncol_nz) begin
                    state_next = mp2w_pkg::ST_WINIT;
                end else if (status.x_last) begin
                    state_next = mp2w_pkg::ST_ROWADV;
                end else begin
                    state_next = mp2w_pkg::ST_ADVANCE;
                end
            end
            mp2w_pkg::ST_WINIT: begin
                cmd.win_init = 1'b1;
                state_next   = mp2w_pkg::ST_WIN;
            end
            mp2w_pkg::ST_WIN: begin
                cmd.win_step = 1'b1;
                if (status.win_done) begin
                    state_next = mp2w_pkg::ST_DRAIN;
                end
            end
            mp2w_pkg::ST_DRAIN: begin
                cmd.load_out = 1'b1;
                state_next   = mp2w_pkg::ST_OUT;
            end
            mp2w_pkg::ST_OUT: begin
                m_valid = 1'b1;
                if (m_tready) begin
                    cmd.out_done = 1'b1;
                    if (status.last) begin
                        state_next = status.x_last ? mp2w_pkg::ST_ROWADV
                                                   : mp2w_pkg::ST_ADVANCE;
                    end else if (status.col_more) begin
                        state_next = mp2w_pkg::ST_WINIT;
                    end else begin
                        state_next = mp2w_pkg::ST_ROW;
                    end
                end
            end
            mp2w_pkg::ST_ROWADV: begin
                if (status.row_hit_base) begin
                    cmd.row_adv = 1'b1;
                end else begin
                    state_next = mp2w_pkg::ST_ADVANCE;
                end
            end
            mp2w_pkg::ST_ADVANCE: begin
                cmd.advance = 1'b1;
                state_next  = mp2w_pkg::ST_IDLE;
            end
            default: begin
                state_next = mp2w_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/mp2w_datapath.sv =====
// ----------------------------------------------------------------------------
// mp2w_datapath
// line store, position and trigger counters, window walker and max reduction
// ----------------------------------------------------------------------------
`default_nettype none

module mp2w_datapath #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_KERNEL = 8,
    parameter int DATA_BITS  = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  mp2w_pkg::cmd_t                            cmd,
    input  wire logic                                 restart,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0]       w_eff,
    input  wire logic [mp2w_pkg::Y_W-1:0]             h_eff,
    input  wire logic [mp2w_pkg::K_W-1:0]             k_eff,
    input  wire logic [mp2w_pkg::S_W-1:0]             s_eff,
    input  wire logic [mp2w_pkg::P_W-1:0]             p_eff,
    input  wire logic signed [DATA_BITS-1:0]          pixel,
    output mp2w_pkg::status_t                         status,
    output logic signed [DATA_BITS-1:0]               pool_max,
    output logic [mp2w_pkg::OUT_X_W-1:0]              out_x,
    output logic [mp2w_pkg::OUT_Y_W-1:0]              out_y,
    output logic                                      run_last,
    output logic                                      plane_end
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int EXW = WW + 3;
    localparam int SW  = $clog2(MAX_KERNEL);
    localparam int EYW = mp2w_pkg::EY_W;
    localparam int YW  = mp2w_pkg::Y_W;
    localparam int NW  = mp2w_pkg::NCOL_W;
    localparam int RW  = mp2w_pkg::RREM_W;
    localparam int NCW = mp2w_pkg::CNT_W;
    localparam logic signed [DATA_BITS-1:0] DATA_MIN = {1'b1, {(DATA_BITS-1){1'b0}}};

    // line store, row y in slot y mod MAX_KERNEL
    logic signed [DATA_BITS-1:0] mem [MAX_KERNEL][MAX_WIDTH];
    logic signed [DATA_BITS-1:0] rdata_reg;

    // position and trigger counters
    logic [CW-1:0]  col_reg, col_next;
    logic [YW-1:0]  row_reg, row_next;
    logic [SW-1:0]  slot_reg, slot_next;
    logic [EXW-1:0] ox_base_reg, ox_base_next;
    logic [EYW-1:0] oy_base_reg, oy_base_next;
    logic [EXW-1:0] ox_first_reg, ox_first_next;
    logic [EXW-1:0] ox_cur_reg, ox_cur_next;
    logic [EYW-1:0] oy_cur_reg, oy_cur_next;
    logic [NW-1:0]  ncol_reg, ncol_next;
    logic [NW-1:0]  cidx_reg, cidx_next;
    logic [NCW-1:0] n_reg, n_next;
    logic           rd_valid_reg, rd_valid_next;

    // window walker and reduction
    logic [SW-1:0]  rc_reg, rc_next;
    logic [RW-1:0]  rrem_reg, rrem_next;
    logic [CW-1:0]  cc_reg, cc_next;
    logic [CW-1:0]  crem_reg, crem_next;
    logic [CW-1:0]  ccols_reg, ccols_next;
    logic signed [DATA_BITS-1:0] acc_reg, acc_next;

    logic signed [DATA_BITS-1:0] pool_reg;
    logic [EXW-1:0] ox_out_reg;
    logic [EYW-1:0] oy_out_reg;
    logic           last_reg, pend_reg;

    logic [mp2w_pkg::K_W-1:0] base;
    logic [EXW-1:0] lim_x, km1_x, ex_base, ex_cur, sx;
    logic [EYW-1:0] lim_y, km1_y, ey_base, ey_cur, ey_nxt, sy;
    logic           x_last, y_last, col_more, hit_cur, hit_base, hit_nxt, last_now;
    logic [CW-1:0]  crem_init;
    logic [RW-1:0]  rrem_init;
    logic signed [DATA_BITS-1:0] acc_full;

    function automatic logic hit_y(input logic [EYW-1:0] ey, input logic [EYW-1:0] lim,
                                   input logic [YW-1:0] yv, input logic ylast);
        return (ey <= lim) && ((ey == EYW'(yv)) || ylast);
    endfunction

    always_comb begin
        base     = k_eff - mp2w_pkg::K_W'(1) - mp2w_pkg::K_W'(p_eff);
        lim_x    = EXW'(w_eff) + EXW'(p_eff) + EXW'(s_eff) - EXW'(2);
        lim_y    = EYW'(h_eff) + EYW'(p_eff) + EYW'(s_eff) - EYW'(2);
        km1_x    = EXW'(k_eff) - EXW'(1);
        km1_y    = EYW'(k_eff) - EYW'(1);
        x_last   = (WW'(col_reg) == (w_eff - WW'(1)));
        y_last   = (row_reg == (h_eff - YW'(1)));

        // window end of an output index: index * stride - pad + kernel - 1
        ex_base  = EXW'(ox_base_reg * s_eff) + EXW'(base);
        ex_cur   = EXW'(ox_cur_reg * s_eff) + EXW'(base);
        ey_base  = EYW'(oy_base_reg * s_eff) + EYW'(base);
        ey_cur   = EYW'(oy_cur_reg * s_eff) + EYW'(base);
        ey_nxt   = EYW'((oy_cur_reg + EYW'(1)) * s_eff) + EYW'(base);

        hit_cur  = hit_y(ey_cur, lim_y, row_reg, y_last);
        hit_base = hit_y(ey_base, lim_y, row_reg, y_last);
        hit_nxt  = hit_y(ey_nxt, lim_y, row_reg, y_last);
        col_more = ((NW+1)'(cidx_reg) + (NW+1)'(1)) < (NW+1)'(ncol_reg);
        last_now = (n_reg == NCW'(mp2w_pkg::RESULT_CAP - 1)) || (!col_more && !hit_nxt);

        // clamped window start, walked back from the current pixel
        sx = ex_cur - km1_x;
        sy = ey_cur - km1_y;
        if (ex_cur < km1_x) begin
            crem_init = col_reg;
        end else if (sx >= EXW'(col_reg)) begin
            crem_init = '0;
        end else begin
            crem_init = CW'(EXW'(col_reg) - sx);
        end
        if (ey_cur < km1_y) begin
            rrem_init = RW'(row_reg);
        end else if (sy >= EYW'(row_reg)) begin
            rrem_init = '0;
        end else begin
            rrem_init = RW'(EYW'(row_reg) - sy);
        end

        acc_full = (rd_valid_reg && (rdata_reg > acc_reg)) ? rdata_reg : acc_reg;

        status.col_hit      = (ex_base <= lim_x) && ((ex_base == EXW'(col_reg)) || x_last);
        status.row_hit      = hit_cur;
        status.row_hit_base = hit_base;
        status.n_ok         = (n_reg < NCW'(mp2w_pkg::RESULT_CAP));
        status.ncol_nz      = (ncol_reg != '0);
        status.col_more     = col_more;
        status.last         = last_reg;
        status.x_last       = x_last;
        status.win_done     = (crem_reg == '0) && (rrem_reg == '0);
    end

    // counters and control state
    always_comb begin
        col_next      = col_reg;
        row_next      = row_reg;
        slot_next     = slot_reg;
        ox_base_next  = ox_base_reg;
        oy_base_next  = oy_base_reg;
        ox_first_next = ox_first_reg;
        ox_cur_next   = ox_cur_reg;
        oy_cur_next   = oy_cur_reg;
        ncol_next     = ncol_reg;
        cidx_next     = cidx_reg;
        n_next        = n_reg;
        rd_valid_next = cmd.win_step;
        if (cmd.accept) begin
            n_next        = '0;
            ncol_next     = '0;
            cidx_next     = '0;
            ox_first_next = ox_base_reg;
            ox_cur_next   = ox_base_reg;
            oy_cur_next   = oy_base_reg;
        end
        if (cmd.col_step) begin
            ox_base_next = ox_base_reg + EXW'(1);
            ncol_next    = ncol_reg + NW'(1);
        end
        if (cmd.out_done) begin
            n_next = n_reg + NCW'(1);
            if (col_more) begin
                ox_cur_next = ox_cur_reg + EXW'(1);
                cidx_next   = cidx_reg + NW'(1);
            end else begin
                oy_cur_next = oy_cur_reg + EYW'(1);
                ox_cur_next = ox_first_reg;
                cidx_next   = '0;
            end
        end
        if (cmd.row_adv) begin
            oy_base_next = oy_base_reg + EYW'(1);
        end
        if (cmd.advance) begin
            if (x_last) begin
                col_next     = '0;
                ox_base_next = '0;
                if (y_last) begin
                    row_next     = '0;
                    slot_next    = '0;
                    oy_base_next = '0;
                end else begin
                    row_next  = row_reg + YW'(1);
                    slot_next = (slot_reg == SW'(MAX_KERNEL - 1)) ? '0 : slot_reg + SW'(1);
                end
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
        if (restart) begin
            col_next     = '0;
            row_next     = '0;
            slot_next    = '0;
            ox_base_next = '0;
            oy_base_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            slot_reg     <= '0;
            ox_base_reg  <= '0;
            oy_base_reg  <= '0;
            ox_first_reg <= '0;
            ox_cur_reg   <= '0;
            oy_cur_reg   <= '0;
            ncol_reg     <= '0;
            cidx_reg     <= '0;
            n_reg        <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            slot_reg     <= slot_next;
            ox_base_reg  <= ox_base_next;
            oy_base_reg  <= oy_base_next;
            ox_first_reg <= ox_first_next;
            ox_cur_reg   <= ox_cur_next;
            oy_cur_reg   <= oy_cur_next;
            ncol_reg     <= ncol_next;
            cidx_reg     <= cidx_next;
            n_reg        <= n_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    // window walk: columns right to left, then the row above
    always_comb begin
        rc_next    = rc_reg;
        rrem_next  = rrem_reg;
        cc_next    = cc_reg;
        crem_next  = crem_reg;
        ccols_next = ccols_reg;
        acc_next   = acc_full;
        if (cmd.win_init) begin
            rc_next    = slot_reg;
            rrem_next  = rrem_init;
            cc_next    = col_reg;
            crem_next  = crem_init;
            ccols_next = crem_init;
            acc_next   = DATA_MIN;
        end else if (cmd.win_step) begin
            if (crem_reg != '0) begin
                cc_next   = cc_reg - CW'(1);
                crem_next = crem_reg - CW'(1);
            end else if (rrem_reg != '0) begin
                rc_next   = (rc_reg == '0) ? SW'(MAX_KERNEL - 1) : rc_reg - SW'(1);
                rrem_next = rrem_reg - RW'(1);
                cc_next   = col_reg;
                crem_next = ccols_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rc_reg    <= rc_next;
        rrem_reg  <= rrem_next;
        cc_reg    <= cc_next;
        crem_reg  <= crem_next;
        ccols_reg <= ccols_next;
        acc_reg   <= acc_next;
        if (cmd.load_out) begin
            pool_reg   <= acc_full;
            ox_out_reg <= ox_cur_reg;
            oy_out_reg <= oy_cur_reg;
            last_reg   <= last_now;
            pend_reg   <= last_now && x_last && y_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            mem[slot_reg][col_reg] <= pixel;
        end
        if (cmd.win_step) begin
            rdata_reg <= mem[rc_reg][cc_reg];
        end
    end

    assign pool_max  = pool_reg;
    assign out_x     = mp2w_pkg::OUT_X_W'(ox_out_reg);
    assign out_y     = mp2w_pkg::OUT_Y_W'(oy_out_reg);
    assign run_last  = last_reg;
    assign plane_end = pend_reg;

endmodule

`default_nettype wire

// ===== rtl/max_pool_2d_window_core.sv =====
// sequence: a transfer state takes the pixel, a column scan counts the triggered columns, then
// a row check; each result then takes a window init, a walk with one line store read per cycle
// over the clamped window, a drain and its output transfer; each further output row adds a row
// check, a row end steps the output row base past every closed output row, and a final advance
// closes the pixel; one pixel in flight, a new pixel is taken only once the last one is through
// reset: aresetn synchronous active low, plane restarts, line store kept, config write restarts
// ----------------------------------------------------------------------------
// max_pool_2d_window_core
// 2-d max pooling over a raster pixel stream with clamped window edges
// ----------------------------------------------------------------------------
`default_nettype none

module max_pool_2d_window_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_KERNEL = 8,
    parameter int DATA_BITS  = 16
) (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    // pixel stream in
    input  wire logic                                      s_tvalid,
    output logic                                           s_tready,
    input  wire logic [((DATA_BITS+7)/8)*8-1:0]            s_tdata,   // pixel
    // pooled results out
    output logic                                           m_tvalid,
    input  wire logic                                      m_tready,
    output logic [((DATA_BITS+mp2w_pkg::OUT_X_W+mp2w_pkg::OUT_Y_W+7)/8)*8-1:0] m_tdata,
                                                             // pool_max, out_x, out_y
    output logic                                           m_tlast,   // run_last
    output logic                                           m_tuser,   // plane_end
    // register writes
    input  wire logic                                      cfg_wr_en,
    input  wire logic [mp2w_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  wire logic [mp2w_pkg::CFG_DATA_W-1:0]           cfg_wdata
);

    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int MDW  = ((DATA_BITS + mp2w_pkg::OUT_X_W + mp2w_pkg::OUT_Y_W + 7) / 8) * 8;

    // configuration registers, raw as written
    logic [mp2w_pkg::W_REG_W-1:0] in_width_reg;
    logic [mp2w_pkg::Y_W-1:0]     in_height_reg;
    logic [mp2w_pkg::K_W-1:0]     kernel_size_reg;
    logic [mp2w_pkg::S_W-1:0]     stride_reg;
    logic [mp2w_pkg::P_W-1:0]     pad_reg;
    logic                         restart;

    // effective values after saturation
    logic [WW-1:0]                w_eff;
    logic [mp2w_pkg::Y_W-1:0]     h_eff;
    logic [mp2w_pkg::K_W-1:0]     k_eff;
    logic [mp2w_pkg::S_W-1:0]     s_eff;
    logic [mp2w_pkg::P_W-1:0]     p_eff;

    mp2w_pkg::cmd_t               cmd;
    mp2w_pkg::status_t            status;

    logic signed [DATA_BITS-1:0]  pool_max;
    logic [mp2w_pkg::OUT_X_W-1:0] out_x;
    logic [mp2w_pkg::OUT_Y_W-1:0] out_y;

    // a write to a listed register restarts the plane, unlisted indexes are ignored
    always_comb begin
        case (mp2w_pkg::cfg_reg_t'(cfg_index))
            mp2w_pkg::REG_IN_WIDTH,
            mp2w_pkg::REG_IN_HEIGHT,
            mp2w_pkg::REG_KERNEL_SIZE,
            mp2w_pkg::REG_STRIDE,
            mp2w_pkg::REG_PAD: restart = cfg_wr_en;
            default:           restart = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_width_reg    <= mp2w_pkg::W_REG_W'(1024);
            in_height_reg   <= mp2w_pkg::Y_W'(1);
            kernel_size_reg <= mp2w_pkg::K_W'(2);
            stride_reg      <= mp2w_pkg::S_W'(2);
            pad_reg         <= '0;
        end else if (cfg_wr_en) begin
            case (mp2w_pkg::cfg_reg_t'(cfg_index))
                mp2w_pkg::REG_IN_WIDTH: begin
                    in_width_reg <= cfg_wdata[mp2w_pkg::W_REG_W-1:0];
                end
                mp2w_pkg::REG_IN_HEIGHT: begin
                    in_height_reg <= cfg_wdata[mp2w_pkg::Y_W-1:0];
                end
                mp2w_pkg::REG_KERNEL_SIZE: begin
                    kernel_size_reg <= cfg_wdata[mp2w_pkg::K_W-1:0];
                end
                mp2w_pkg::REG_STRIDE: begin
                    stride_reg <= cfg_wdata[mp2w_pkg::S_W-1:0];
                end
                mp2w_pkg::REG_PAD: begin
                    pad_reg <= cfg_wdata[mp2w_pkg::P_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // zero width, height, kernel or stride acts as one, width and kernel saturate to the build limits,
    // pad saturates to kernel minus one
    always_comb begin
        if (in_width_reg == '0) begin
            w_eff = WW'(1);
        end else if (32'(in_width_reg) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(in_width_reg);
        end
        h_eff = (in_height_reg == '0) ? mp2w_pkg::Y_W'(1) : in_height_reg;
        if (kernel_size_reg == '0) begin
            k_eff = mp2w_pkg::K_W'(1);
        end else if (32'(kernel_size_reg) > 32'(MAX_KERNEL)) begin
            k_eff = mp2w_pkg::K_W'(MAX_KERNEL);
        end else begin
            k_eff = kernel_size_reg;
        end
        s_eff = (stride_reg == '0) ? mp2w_pkg::S_W'(1) : stride_reg;
        if (mp2w_pkg::K_W'(pad_reg) > (k_eff - mp2w_pkg::K_W'(1))) begin
            p_eff = mp2w_pkg::P_W'(k_eff - mp2w_pkg::K_W'(1));
        end else begin
            p_eff = pad_reg;
        end
    end

    // sequencer
    mp2w_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd),
        .s_ready  (s_tready),
        .m_valid  (m_tvalid)
    );

    // line store, counters and max reduction
    mp2w_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_KERNEL (MAX_KERNEL),
        .DATA_BITS  (DATA_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .restart   (restart),
        .w_eff     (w_eff),
        .h_eff     (h_eff),
        .k_eff     (k_eff),
        .s_eff     (s_eff),
        .p_eff     (p_eff),
        .pixel     (s_tdata[DATA_BITS-1:0]),
        .status    (status),
        .pool_max  (pool_max),
        .out_x     (out_x),
        .out_y     (out_y),
        .run_last  (m_tlast),
        .plane_end (m_tuser)
    );

    // result fields packed from the lowest bit, zero filled to whole bytes
    assign m_tdata = MDW'({out_y, out_x, pool_max});

endmodule

`default_nettype wire

// ===== rtl/mp2w_checker.sv =====
// ----------------------------------------------------------------------------
// mp2w_checker
// port level checks of the pooling core, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module mp2w_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_tready,
    input wire logic m_tvalid,
    input wire logic m_tready,
    input wire logic m_tlast,
    input wire logic m_tuser
);

    // a held result stays until its transfer
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped before transfer");

    // one item in flight: no input taken while a result is offered
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    // nothing offered straight after reset
    a_reset_quiet: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result offered after reset");

    // plane end is always the last of its run
    a_plane_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("plane end without run end");

endmodule

bind max_pool_2d_window_core mp2w_checker u_mp2w_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the 2-d max pooling window core: pixel planes go in
// under random sender gaps and receiver stalls, a local model of the window
// arithmetic predicts every pooled result and the bench compares each field
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_W  = 1024;   // line store width of the instance
    localparam int LINES   = 8;      // rows kept in the line store
    localparam int PIX_W   = 16;
    localparam int RUN_CAP = 64;     // most results a single pixel may cause

    // one expected pooled result
    typedef struct {
        logic [PIX_W-1:0]             pool_max;
        logic [mp2w_pkg::OUT_X_W-1:0] out_x;
        logic [mp2w_pkg::OUT_Y_W-1:0] out_y;
        logic                         run_last;
        logic                         plane_end;
    } pool_result_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [15:0]                     s_tdata = '0;     // pixel
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [47:0]                     m_tdata;          // pool_max, out_x, out_y
    logic                            m_tlast;          // run_last
    logic                            m_tuser;          // plane_end
    logic                            cfg_wr_en = 1'b0;
    logic [mp2w_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [mp2w_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    max_pool_2d_window_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------
    // local model of the pooling window
    // ------------------------------------------------------------------
    pool_result_t pooled_q[$];          // results still owed by the core
    logic signed [PIX_W-1:0] line_mem[LINES][LINE_W];
    int  reg_width  = 1024;             // register values as written, masked
    int  reg_height = 1;
    int  reg_kernel = 2;
    int  reg_stride = 2;
    int  reg_pad    = 0;
    int  col_pos    = 0;
    int  row_pos    = 0;
    int  fail_count = 0;
    int  pixels_sent = 0;

    function automatic int clampi(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // outputs along one dimension, zero when the window never fits
    function automatic int pooled_len(int dim, int k, int s, int p);
        int n;
        int o;
        n = dim + 2 * p - k;
        if (n >= 0) o = (n + s - 1) / s + 1;
        else o = 1 - ((-n) / s);
        return (o < 0) ? 0 : o;
    endfunction

    // output indices whose clamped window closes at position pos
    task automatic closing_span(input int pos, dim, k, s, p, osz, output int lo, hi);
        int t;
        t  = pos + p - k + 1;
        lo = (t <= 0) ? 0 : (t + s - 1) / s;
        if (pos < dim - 1) hi = (t < 0) ? -1 : t / s;
        else hi = osz - 1;
        if (hi > osz - 1) hi = osz - 1;
    endtask

    // store the pixel and queue every window that it completes
    task automatic predict_pooling(input logic [PIX_W-1:0] pix);
        int w, h, k, s, p, oxn, oyn, xlo, xhi, ylo, yhi, x0, x1, y0, y1, n;
        logic signed [PIX_W-1:0] best;
        pool_result_t res;
        w = (reg_width == 0) ? 1 : ((reg_width > LINE_W) ? LINE_W : reg_width);
        h = (reg_height == 0) ? 1 : reg_height;
        k = (reg_kernel == 0) ? 1 : ((reg_kernel > LINES) ? LINES : reg_kernel);
        s = (reg_stride == 0) ? 1 : reg_stride;
        p = (reg_pad > k - 1) ? k - 1 : reg_pad;
        n = 0;
        if (col_pos >= w) col_pos = 0;
        if (row_pos >= h) row_pos = 0;
        line_mem[row_pos % LINES][col_pos] = pix;
        oxn = pooled_len(w, k, s, p);
        oyn = pooled_len(h, k, s, p);
        closing_span(col_pos, w, k, s, p, oxn, xlo, xhi);
        closing_span(row_pos, h, k, s, p, oyn, ylo, yhi);
        for (int oy = ylo; oy <= yhi && n < RUN_CAP; oy++) begin
            for (int ox = xlo; ox <= xhi && n < RUN_CAP; ox++) begin
                x0 = clampi(ox * s - p, 0, w - 1);
                x1 = clampi(ox * s - p + k - 1, 0, w - 1);
                y0 = clampi(oy * s - p, 0, h - 1);
                y1 = clampi(oy * s - p + k - 1, 0, h - 1);
                best = line_mem[y0 % LINES][x0];
                for (int r = y0; r <= y1; r++)
                    for (int c = x0; c <= x1; c++)
                        if (line_mem[r % LINES][c] > best) best = line_mem[r % LINES][c];
                res.pool_max  = best;
                res.out_x     = ox[mp2w_pkg::OUT_X_W-1:0];
                res.out_y     = oy[mp2w_pkg::OUT_Y_W-1:0];
                res.run_last  = 1'b0;
                res.plane_end = 1'b0;
                pooled_q.push_back(res);
                n++;
            end
        end
        // the last of the run is marked, and flagged when the plane closes
        if (n > 0) begin
            pooled_q[$].run_last  = 1'b1;
            pooled_q[$].plane_end = (col_pos == w - 1) && (row_pos == h - 1);
        end
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
    endtask

    // ------------------------------------------------------------------
    // result side: stall pattern and long hold-off
    // ------------------------------------------------------------------
    int   stall_mode = 0;               // 0 always ready, 1 light, 2 heavy
    logic hold_tog = 1'b0;              // toggled by a test to ask for a hold-off
    logic hold_seen = 1'b0;
    int   hold_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_seen <= hold_tog;
            hold_left <= 0;
        end else if (hold_tog != hold_seen) begin
            // long stretch with the receiver held off
            hold_seen <= hold_tog;
            hold_left <= 400;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 4) != 0);
                default: m_tready <= ($urandom_range(0, 2) == 0);
            endcase
        end
    end

    task automatic report(input string what, input longint exp_v, input longint act_v);
        $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, what, exp_v, act_v);
        fail_count++;
    endtask

    // compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        pool_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pooled_q.size() == 0) begin
                $display("%0t ns: unexpected result, expected none actual %0h", $time,
                         m_tdata);
                fail_count++;
            end else begin
                want = pooled_q.pop_front();
                if (m_tdata[15:0] !== want.pool_max)
                    report("pool_max", want.pool_max, m_tdata[15:0]);
                if (m_tdata[26:16] !== want.out_x)
                    report("out_x", want.out_x, m_tdata[26:16]);
                if (m_tdata[43:27] !== want.out_y)
                    report("out_y", want.out_y, m_tdata[43:27]);
                if (m_tlast !== want.run_last)
                    report("run_last", want.run_last, m_tlast);
                if (m_tuser !== want.plane_end)
                    report("plane_end", want.plane_end, m_tuser);
            end
        end
    end

    // ------------------------------------------------------------------
    // pixel side
    // ------------------------------------------------------------------
    int burst_left = 0;
    bit sender_gaps = 0;

    // offer one pixel, honouring the burst and gap pattern
    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        if (sender_gaps && burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0) burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do @(posedge aclk); while (!s_tready);
        predict_pooling(pix);
        pixels_sent++;
    endtask

    // stop offering and let the core go quiet
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pooled_q.size() != 0) @(posedge aclk);
        // pixels with no result may still be in the scan
        repeat (100) @(posedge aclk);
    endtask

    // register write, only issued with the core drained; the caller drops the enable
    task automatic write_reg(input mp2w_pkg::cfg_reg_t idx, input int value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[mp2w_pkg::CFG_DATA_W-1:0];
        @(posedge aclk);
        case (idx)
            mp2w_pkg::REG_IN_WIDTH:    reg_width  = value & 'h7FF;
            mp2w_pkg::REG_IN_HEIGHT:   reg_height = value & 'hFFFF;
            mp2w_pkg::REG_KERNEL_SIZE: reg_kernel = value & 'hF;
            mp2w_pkg::REG_STRIDE:      reg_stride = value & 'hF;
            mp2w_pkg::REG_PAD:         reg_pad    = value & 'h7;
            default: ;
        endcase
        col_pos = 0;
        row_pos = 0;
    endtask

    task automatic set_plane(input int w, h, k, s, p);
        write_reg(mp2w_pkg::REG_IN_WIDTH, w);
        write_reg(mp2w_pkg::REG_IN_HEIGHT, h);
        write_reg(mp2w_pkg::REG_KERNEL_SIZE, k);
        write_reg(mp2w_pkg::REG_STRIDE, s);
        write_reg(mp2w_pkg::REG_PAD, p);
        cfg_wr_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // register defaults straight after reset: one row, 2x2 windows, stride 2
    task automatic test_reset_defaults;
        for (int i = 0; i < 6; i++) send_pixel($urandom);
        drain();
    endtask

    // sample extremes through a padded 2x2 window with stride 1
    task automatic test_sample_extremes;
        logic [PIX_W-1:0] corner[12] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                                         16'h0001, 16'h8001, 16'h7FFE, 16'h0100,
                                         16'hFF00, 16'h8000, 16'h8000, 16'h7FFF};
        set_plane(4, 3, 2, 1, 1);
        foreach (corner[i]) send_pixel(corner[i]);
        drain();
    endtask

    // zero registers act as one, oversize kernel saturates, pad is cut to k-1
    task automatic test_register_extremes;
        set_plane(0, 0, 0, 0, 7);
        for (int i = 0; i < 3; i++) send_pixel($urandom);
        drain();
        // single-pixel plane with the widest padded window: a full run of results
        set_plane(1, 1, 15, 1, 7);
        for (int i = 0; i < 2; i++) send_pixel($urandom);
        drain();
        // oversize width saturates to the line store, widest kernel with an equal stride
        set_plane(2047, 1, 8, 8, 0);
        for (int i = 0; i < 64; i++) send_pixel($urandom);
        drain();
        // tallest plane, only its first pixels
        set_plane(3, 65535, 3, 15, 2);
        for (int i = 0; i < 9; i++) send_pixel($urandom);
        drain();
    endtask

    // window never fits: pixels go in and nothing comes out
    task automatic test_empty_plane;
        set_plane(2, 2, 8, 1, 0);
        for (int i = 0; i < 4; i++) send_pixel($urandom);
        drain();
    endtask

    // receiver held off while pixels keep coming, so the core backs up
    task automatic test_backpressure;
        set_plane(6, 5, 3, 1, 2);
        hold_tog <= ~hold_tog;
        for (int i = 0; i < 30; i++) send_pixel($urandom);
        drain();
    endtask

    // random small planes with random content and idling
    task automatic test_random_planes;
        int w, h, planes, cut;
        while (pixels_sent < 440) begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            set_plane(w | ($urandom_range(0, 1) << 10), h, $urandom_range(0, 15),
                      $urandom_range(0, 15), $urandom_range(0, 7));
            stall_mode  = $urandom_range(0, 2);
            sender_gaps = $urandom_range(0, 3) != 0;
            planes = $urandom_range(1, 2);
            // mostly whole planes, now and then a plane cut short
            if ($urandom_range(0, 5) == 0) begin
                cut = $urandom_range(1, w * h);
                for (int i = 0; i < cut; i++) send_pixel($urandom);
            end else begin
                for (int i = 0; i < planes * w * h; i++) send_pixel($urandom);
            end
            drain();
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        stall_mode  = 1;
        sender_gaps = 1;
        test_sample_extremes();
        test_register_extremes();
        test_empty_plane();
        test_backpressure();
        test_random_planes();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // overall watchdog
    initial begin
        #300_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
